// File: hdl/mbsd_pkg.sv
package mbsd_pkg;

    localparam int HDR_LEN     = 7;
    localparam int FRAME_LIMIT = 260;
    localparam int Q_DEPTH     = 16;
    localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);
    localparam int HDR_IDX_W   = $clog2(HDR_LEN);
    localparam int PUSH_W      = $clog2(HDR_LEN + 1);

    localparam logic [8:0] TOTAL_CAP       = 9'(FRAME_LIMIT);
    localparam logic [8:0] MAX_TOTAL_RESET = 9'd260;

    localparam logic [0:0] OP_DATA  = 1'b0;
    localparam logic [0:0] OP_RESET = 1'b1;

    localparam logic [1:0] KIND_FRAME   = 2'd0;
    localparam logic [1:0] KIND_DISCARD = 2'd1;
    localparam logic [1:0] KIND_ABORT   = 2'd2;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] out_byte;
        logic       frame_first;
        logic       frame_last;
        logic [8:0] frame_total;
    } result_t;

    typedef struct packed {
        logic [PUSH_W-1:0]         count;
        result_t [HDR_LEN-1:0]     res;
    } push_t;

endpackage

// File: hdl/mbsd_cell.sv
module mbsd_cell (
    input  logic             aclk,
    input  logic             shift,
    input  logic             load,
    input  mbsd_pkg::result_t load_data,
    input  mbsd_pkg::result_t nbr_data,
    output mbsd_pkg::result_t q
);
    import mbsd_pkg::*;

    result_t data_reg;
    result_t data_next;

    always_comb begin
        data_next = data_reg;
        if (load) begin
            data_next = load_data;
        end else if (shift) begin
            data_next = nbr_data;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign q = data_reg;

endmodule

// File: hdl/mbsd_queue.sv
module mbsd_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  mbsd_pkg::push_t    push,
    input  logic               pop,
    output logic               not_empty,
    output logic               has_room,
    output mbsd_pkg::result_t  head
);
    import mbsd_pkg::*;

    logic [Q_CNT_W-1:0] cnt_reg;
    logic [Q_CNT_W-1:0] cnt_next;
    logic [Q_CNT_W-1:0] wr_base;
    result_t            cell_q [Q_DEPTH];

    // slots free after pop are filled from wr_base upward
    assign wr_base  = cnt_reg - Q_CNT_W'(pop);
    assign cnt_next = wr_base + Q_CNT_W'(push.count);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    genvar j;
    generate
        for (j = 0; j < Q_DEPTH; j++) begin : g_cell
            logic [Q_CNT_W-1:0] offs;
            logic               wr;
            result_t            nbr;
            assign offs = Q_CNT_W'(j) - wr_base;
            assign wr   = offs < Q_CNT_W'(push.count);
            if (j == Q_DEPTH - 1) begin : g_top
                assign nbr = '0;
            end else begin : g_mid
                assign nbr = cell_q[j+1];
            end
            mbsd_cell u_cell (
                .aclk      (aclk),
                .shift     (pop),
                .load      (wr),
                .load_data (push.res[offs[HDR_IDX_W-1:0]]),
                .nbr_data  (nbr),
                .q         (cell_q[j])
            );
        end
    endgenerate

    assign not_empty = cnt_reg != '0;
    // a full header burst must always fit
    assign has_room  = cnt_reg <= Q_CNT_W'(Q_DEPTH - HDR_LEN);
    assign head      = cell_q[0];

endmodule

// File: hdl/mbsd_parser.sv
module mbsd_parser (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_fire,
    input  logic            opcode,
    input  logic [7:0]      data_byte,
    input  logic [8:0]      max_total,
    output mbsd_pkg::push_t push
);
    import mbsd_pkg::*;

    logic [7:0]           win_reg  [HDR_LEN];
    logic [7:0]           win_next [HDR_LEN];
    logic [7:0]           win_new  [HDR_LEN];
    logic [2:0]           wc_reg, wc_next;
    logic                 in_frame_reg, in_frame_next;
    logic [8:0]           rem_reg, rem_next;
    logic [8:0]           total_reg, total_next;
    logic [HDR_IDX_W-1:0] idx;
    logic [8:0]           limit;
    logic [15:0]          pid, len;
    logic [16:0]          sum;
    logic [8:0]           total;
    logic                 hdr_ok;
    logic                 is_last;

    assign limit = (max_total > TOTAL_CAP) ? TOTAL_CAP : max_total;
    assign idx   = (wc_reg >= 3'(HDR_LEN)) ? HDR_IDX_W'(HDR_LEN - 1) : wc_reg[HDR_IDX_W-1:0];

    always_comb begin
        for (int i = 0; i < HDR_LEN; i++) begin
            win_new[i] = (HDR_IDX_W'(i) == idx) ? data_byte : win_reg[i];
        end
    end

    assign pid     = {win_new[2], win_new[3]};
    assign len     = {win_new[4], win_new[5]};
    assign sum     = 17'd6 + {1'b0, len};
    assign total   = sum[8:0];
    assign hdr_ok  = (pid == '0) && (len != '0) && (sum <= {8'd0, limit});
    assign is_last = rem_reg <= 9'd1;

    always_comb begin
        push          = '0;
        win_next      = win_reg;
        wc_next       = wc_reg;
        in_frame_next = in_frame_reg;
        rem_next      = rem_reg;
        total_next    = total_reg;
        if (in_fire) begin
            if (opcode == OP_RESET) begin
                if (in_frame_reg) begin
                    push.count       = PUSH_W'(1);
                    push.res[0].kind = KIND_ABORT;
                end
                for (int i = 0; i < HDR_LEN; i++) begin
                    win_next[i] = '0;
                end
                wc_next       = '0;
                in_frame_next = 1'b0;
                rem_next      = '0;
                total_next    = '0;
            end else if (in_frame_reg) begin
                push.count                = PUSH_W'(1);
                push.res[0].kind          = KIND_FRAME;
                push.res[0].out_byte      = data_byte;
                push.res[0].frame_last    = is_last;
                push.res[0].frame_total   = total_reg;
                if (is_last) begin
                    in_frame_next = 1'b0;
                    rem_next      = '0;
                    total_next    = '0;
                end else begin
                    rem_next = rem_reg - 9'd1;
                end
            end else if (32'(idx) < HDR_LEN - 1) begin
                // window still filling
                win_next = win_new;
                wc_next  = 3'(idx) + 3'd1;
            end else if (hdr_ok) begin
                push.count = PUSH_W'(HDR_LEN);
                for (int i = 0; i < HDR_LEN; i++) begin
                    push.res[i].kind        = KIND_FRAME;
                    push.res[i].out_byte    = win_new[i];
                    push.res[i].frame_first = (i == 0);
                    push.res[i].frame_last  = (i == HDR_LEN - 1) && (total == 9'(HDR_LEN));
                    push.res[i].frame_total = total;
                    win_next[i]             = '0;
                end
                wc_next = '0;
                if (total > 9'(HDR_LEN)) begin
                    in_frame_next = 1'b1;
                    rem_next      = total - 9'(HDR_LEN);
                    total_next    = total;
                end
            end else begin
                // bad header: drop oldest byte and slide
                push.count           = PUSH_W'(1);
                push.res[0].kind     = KIND_DISCARD;
                push.res[0].out_byte = win_new[0];
                for (int i = 0; i < HDR_LEN - 1; i++) begin
                    win_next[i] = win_new[i+1];
                end
                win_next[HDR_LEN-1] = '0;
                wc_next             = 3'(HDR_LEN - 1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < HDR_LEN; i++) begin
                win_reg[i] <= '0;
            end
            wc_reg       <= '0;
            in_frame_reg <= 1'b0;
            rem_reg      <= '0;
            total_reg    <= '0;
        end else begin
            win_reg      <= win_next;
            wc_reg       <= wc_next;
            in_frame_reg <= in_frame_next;
            rem_reg      <= rem_next;
            total_reg    <= total_next;
        end
    end

endmodule

// File: hdl/mbsd_stream_deframer.sv
// channel   | dir | handshake              | payload
// ----------+-----+------------------------+-------------------------------------------
// s_        | in  | s_tvalid / s_tready    | s_tdata: data_byte; s_tuser: opcode
// m_        | out | m_tvalid / m_tready    | m_tdata: out_byte, frame_first, frame_total
//           |     |                        | m_tuser: kind; m_tlast: frame_last
// cfg_      | in  | cfg_valid / cfg_ready  | cfg_data: max_total (always ready)
//
// one word is taken per cycle while s_tready is high; a completed valid header puts
// seven words into a sixteen-cell output queue at once, which drains one word per
// cycle while m_tready is high. s_tready drops only while the queue holds more than
// nine words, so with m_tready high a frame streams at one word per cycle with a
// burst at each header. results leave from the head cell register of the queue.
// aresetn is synchronous and active low; no clearing pass is needed.
module mbap_stream_deframer (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tuser,   // [0] opcode
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [23:0] m_tdata,  // [7:0] out_byte, [8] frame_first, [17:9] frame_total
    output logic [1:0] m_tuser,   // [1:0] kind
    output logic       m_tlast,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [8:0] cfg_data
);
    import mbsd_pkg::*;

    logic [8:0] max_total_reg;
    logic       in_fire;
    logic       room;
    push_t      push;
    result_t    head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_total_reg <= MAX_TOTAL_RESET;
        end else if (cfg_valid && cfg_ready) begin
            max_total_reg <= cfg_data;
        end
    end

    assign s_tready = room;
    assign in_fire  = s_tvalid && room;

    mbsd_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_fire   (in_fire),
        .opcode    (s_tuser),
        .data_byte (s_tdata),
        .max_total (max_total_reg),
        .push      (push)
    );

    mbsd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .pop       (m_tvalid && m_tready),
        .not_empty (m_tvalid),
        .has_room  (room),
        .head      (head)
    );

    assign m_tdata = {6'd0, head.frame_total, head.frame_first, head.out_byte};
    assign m_tuser = head.kind;
    assign m_tlast = head.frame_last;

endmodule
